// ----- src/psnr_pkg.sv -----
package psnr_pkg;

   localparam int COUNT_BITS_DEF  = 26;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [1:0] MODE_8BIT  = 2'd0;
   localparam logic [1:0] MODE_16BIT = 2'd1;
   localparam logic [1:0] MODE_LUMA  = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   localparam logic [2:0] CSR_PIXEL_MODE = 3'd0;
   localparam logic [2:0] CSR_COEF_HIGH  = 3'd1;
   localparam logic [2:0] CSR_COEF_MID   = 3'd2;
   localparam logic [2:0] CSR_COEF_LOW   = 3'd3;
   localparam logic [2:0] CSR_LUMA_OFS   = 3'd4;

   localparam logic signed [17:0] COEF_HIGH_RESET = 18'sd7471;
   localparam logic signed [17:0] COEF_MID_RESET  = 18'sd38470;
   localparam logic signed [17:0] COEF_LOW_RESET  = 18'sd19595;

   // 2560*log10(2) in Q16
   localparam logic [25:0] KDB_Q16   = 26'd50504453;
   localparam logic [16:0] CEIL_L8   = 17'd40481;
   localparam logic [16:0] CEIL_L16  = 17'd52820;
   localparam logic [31:0] PEAK2_8   = 32'd65025;
   localparam logic [31:0] PEAK2_16  = 32'd4294836225;

   typedef struct packed {
      logic [1:0]         pixel_mode;
      logic signed [17:0] coef_high;
      logic signed [17:0] coef_mid;
      logic signed [17:0] coef_low;
      logic signed [24:0] luma_offset;
   } cfg_type;

endpackage

// ----- src/psnr_meter_unit.sv -----
// PSNR meter. Pixel pairs stream in on req_ at one per clock; the front end
// maps each pair to samples (byte, 16-bit or packed-RGB luma per pixel_mode),
// squares the difference and accumulates error and pixel count. The transaction
// with tlast closes the frame and hands its totals through a four-entry queue
// to the back end, which returns one rsp_ transaction: PSNR in signed 1/256 dB
// and an identical flag. The back end works on a frame with a bit-at-a-time
// normalize and a 28-step squaring log2 unit, run twice; a frame with zero
// error or an unsupported mode gets its result without the log2 unit. The
// input stalls only when four closed frames wait in the pipeline and queue
// behind the one the back end is working on.
// Write the csr_ registers only while the block is idle.
module psnr_meter_unit import psnr_pkg::*; #(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // ref_pixel[23:0], test_pixel[47:24]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // psnr_db[16:0], zero fill
   output logic        rsp_tuser,   // identical
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);

   localparam int EW = COUNT_BITS + 67;

   cfg_type                          cfg_ff;
   logic                             push, pop, q_valid;
   logic [EW-1:0]                    push_data, head_data;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   logic [16:0]                      psnr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_mode  <= MODE_8BIT;
         cfg_ff.coef_high   <= COEF_HIGH_RESET;
         cfg_ff.coef_mid    <= COEF_MID_RESET;
         cfg_ff.coef_low    <= COEF_LOW_RESET;
         cfg_ff.luma_offset <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PIXEL_MODE: cfg_ff.pixel_mode  <= csr_wdata[1:0];
            CSR_COEF_HIGH:  cfg_ff.coef_high   <= csr_wdata[17:0];
            CSR_COEF_MID:   cfg_ff.coef_mid    <= csr_wdata[17:0];
            CSR_COEF_LOW:   cfg_ff.coef_low    <= csr_wdata[17:0];
            CSR_LUMA_OFS:   cfg_ff.luma_offset <= csr_wdata;
            default: ;
         endcase
      end
   end

   psnr_front #(.COUNT_BITS(COUNT_BITS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .ref_pixel   (req_tdata[23:0]),
      .test_pixel  (req_tdata[47:24]),
      .last        (req_tlast),
      .queue_count (q_count),
      .push        (push),
      .push_data   (push_data)
   );

   psnr_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (q_valid),
      .head_data (head_data),
      .count     (q_count)
   );

   psnr_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .entry_valid   (q_valid),
      .entry_data    (head_data),
      .pop           (pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_psnr      (psnr),
      .out_identical (rsp_tuser)
   );

   assign rsp_tdata = {7'd0, psnr};

endmodule

// ----- src/psnr_queue.sv -----
module psnr_queue import psnr_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic                       not_empty,
   output logic [WIDTH-1:0]           head_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PW'(1);
         if (push && !pop) count_ff <= count_ff + CW'(1);
         else if (pop && !push) count_ff <= count_ff - CW'(1);
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- src/psnr_front.sv -----
module psnr_front import psnr_pkg::*; #(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cfg_type                          cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [23:0]                      ref_pixel,
   input  logic [23:0]                      test_pixel,
   input  logic                             last,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
   output logic                             push,
   output logic [COUNT_BITS+66:0]           push_data
);

   localparam int CW = $clog2(QUEUE_DEPTH+1);

   // stage 1: luma products
   logic                     s1_valid_ff, s1_last_ff;
   logic [1:0]               s1_mode_ff;
   logic [15:0]              s1_ref_ff, s1_test_ff;
   logic signed [26:0]       ref_prod_ff [3];
   logic signed [26:0]       test_prod_ff [3];
   // stage 2: samples to absolute difference
   logic                     s2_valid_ff, s2_last_ff;
   logic [1:0]               s2_mode_ff;
   logic [15:0]              diff_ff;
   // stage 3: square
   logic                     s3_valid_ff, s3_last_ff;
   logic [1:0]               s3_mode_ff;
   logic [31:0]              sq_ff;
   // accumulators
   logic [63:0]              err_ff;
   logic [COUNT_BITS:0]      cnt_ff;

   logic                     accept;
   logic [1:0]               inflight;
   logic [CW:0]              used;
   logic signed [28:0]       ref_luma, test_luma;
   logic [15:0]              ref_smp, test_smp, diff_in;
   logic [64:0]              sum_wide;
   logic [63:0]              err_in;
   logic [COUNT_BITS:0]      cnt_in;

   function automatic logic [15:0] pick_sample(input logic [1:0] mode, input logic [15:0] px,
                                               input logic signed [28:0] lum);
      logic [15:0] smp;
      case (mode)
         MODE_8BIT:  smp = {8'd0, px[7:0]};
         MODE_16BIT: smp = px;
         // the luma sum stays below 2^27, so no upper clamp is ever reached
         MODE_LUMA:  smp = lum[28] ? 16'd0 : {3'd0, lum[28:16]};
         default:    smp = 16'd0;
      endcase
      return smp;
   endfunction

   assign inflight = 2'(s1_valid_ff & s1_last_ff) + 2'(s2_valid_ff & s2_last_ff)
                   + 2'(s3_valid_ff & s3_last_ff);
   assign used     = (CW+1)'(queue_count) + (CW+1)'(inflight);
   assign in_ready = (used < (CW+1)'(QUEUE_DEPTH));
   assign accept   = in_valid && in_ready;

   always_ff @(posedge clock) begin
      ref_prod_ff[0]  <= cfg.coef_high * $signed({1'b0, ref_pixel[23:16]});
      ref_prod_ff[1]  <= cfg.coef_mid  * $signed({1'b0, ref_pixel[15:8]});
      ref_prod_ff[2]  <= cfg.coef_low  * $signed({1'b0, ref_pixel[7:0]});
      test_prod_ff[0] <= cfg.coef_high * $signed({1'b0, test_pixel[23:16]});
      test_prod_ff[1] <= cfg.coef_mid  * $signed({1'b0, test_pixel[15:8]});
      test_prod_ff[2] <= cfg.coef_low  * $signed({1'b0, test_pixel[7:0]});
      s1_ref_ff       <= ref_pixel[15:0];
      s1_test_ff      <= test_pixel[15:0];
      s1_last_ff      <= last;
      s1_mode_ff      <= cfg.pixel_mode;
      diff_ff         <= diff_in;
      s2_last_ff      <= s1_last_ff;
      s2_mode_ff      <= s1_mode_ff;
      sq_ff           <= diff_ff * diff_ff;
      s3_last_ff      <= s2_last_ff;
      s3_mode_ff      <= s2_mode_ff;
   end

   always_comb begin
      ref_luma  = 29'(ref_prod_ff[0]) + 29'(ref_prod_ff[1]) + 29'(ref_prod_ff[2])
                + 29'(cfg.luma_offset);
      test_luma = 29'(test_prod_ff[0]) + 29'(test_prod_ff[1]) + 29'(test_prod_ff[2])
                + 29'(cfg.luma_offset);
      ref_smp   = pick_sample(s1_mode_ff, s1_ref_ff, ref_luma);
      test_smp  = pick_sample(s1_mode_ff, s1_test_ff, test_luma);
      diff_in   = (ref_smp > test_smp) ? ref_smp - test_smp : test_smp - ref_smp;
      sum_wide  = {1'b0, err_ff} + {33'd0, sq_ff};
      err_in    = sum_wide[64] ? '1 : sum_wide[63:0];
      cnt_in    = cnt_ff[COUNT_BITS] ? cnt_ff : cnt_ff + (COUNT_BITS+1)'(1);
   end

   assign push      = s3_valid_ff && s3_last_ff;
   assign push_data = {s3_mode_ff, err_in, cnt_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         err_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (s3_valid_ff) begin
            if (s3_last_ff) begin
               err_ff <= '0;
               cnt_ff <= '0;
            end else begin
               err_ff <= err_in;
               cnt_ff <= cnt_in;
            end
         end
      end
   end

endmodule

// ----- src/psnr_log2.sv -----
module psnr_log2 import psnr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   output logic        done,
   output logic [33:0] result
);

   typedef enum logic [2:0] {
      L_IDLE = 3'b001,
      L_NORM = 3'b010,
      L_ITER = 3'b100
   } lstate_type;

   lstate_type  state_ff;
   logic [63:0] x_ff;
   logic [5:0]  e_ff;
   logic [31:0] m_ff;
   logic [27:0] frac_ff;
   logic [4:0]  iter_ff;
   logic        done_ff;
   logic [63:0] m_sq;
   logic [32:0] m_next;

   assign m_sq   = m_ff * m_ff;
   assign m_next = m_sq[63:31];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  x_ff     <= x;
                  e_ff     <= 6'd63;
                  state_ff <= L_NORM;
               end
            end
            L_NORM: begin
               // shift up one bit a cycle until the leading one sits at bit 63
               if (x_ff[63]) begin
                  m_ff     <= x_ff[63:32];
                  iter_ff  <= 5'd27;
                  state_ff <= L_ITER;
               end else begin
                  x_ff <= {x_ff[62:0], 1'b0};
                  e_ff <= e_ff - 6'd1;
               end
            end
            L_ITER: begin
               if (m_next[32]) begin
                  m_ff    <= m_next[32:1];
                  frac_ff <= {frac_ff[26:0], 1'b1};
               end else begin
                  m_ff    <= m_next[31:0];
                  frac_ff <= {frac_ff[26:0], 1'b0};
               end
               iter_ff <= iter_ff - 5'd1;
               if (iter_ff == 5'd0) begin
                  done_ff  <= 1'b1;
                  state_ff <= L_IDLE;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = {e_ff, frac_ff};

endmodule

// ----- src/psnr_back.sv -----
module psnr_back import psnr_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   entry_valid,
   input  logic [COUNT_BITS+66:0] entry_data,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [16:0]            out_psnr,
   output logic                   out_identical
);

   localparam int W = COUNT_BITS + 67;

   typedef enum logic [6:0] {
      B_IDLE  = 7'b0000001,
      B_PROD  = 7'b0000010,
      B_LOGA  = 7'b0000100,
      B_LOGB  = 7'b0001000,
      B_SCALE = 7'b0010000,
      B_ROUND = 7'b0100000,
      B_WAIT  = 7'b1000000
   } bstate_type;

   bstate_type          state_ff;
   logic [1:0]          mode_ff;
   logic [63:0]         err_ff;
   logic [COUNT_BITS:0] total_ff;
   logic [63:0]         signal_ff;
   logic [33:0]         la_ff, mag_ff;
   logic                neg_ff;
   logic [59:0]         prod_ff;
   logic                out_valid_ff, out_ident_ff;
   logic [16:0]         out_psnr_ff;
   logic                log_start;
   logic [63:0]         log_x;
   logic                log_done;
   logic [33:0]         log_res;
   logic [1:0]          e_mode;
   logic [63:0]         e_err;
   logic [31:0]         peak2;
   logic signed [34:0]  dl;
   logic [60:0]         rnd_sum;
   logic [16:0]         rnd;

   assign e_mode  = entry_data[W-1:W-2];
   assign e_err   = entry_data[COUNT_BITS+64:COUNT_BITS+1];
   assign peak2   = (mode_ff == MODE_16BIT) ? PEAK2_16 : PEAK2_8;
   assign dl      = $signed({1'b0, la_ff}) - $signed({1'b0, log_res});
   assign rnd_sum = {1'b0, prod_ff} + (61'd1 << 43);
   assign rnd     = rnd_sum[60:44];

   assign pop       = (state_ff == B_IDLE) && entry_valid && !out_valid_ff;
   assign log_start = (state_ff == B_PROD) || ((state_ff == B_LOGA) && log_done);
   assign log_x     = (state_ff == B_PROD) ? signal_ff : err_ff;

   psnr_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (pop) begin
                  mode_ff  <= e_mode;
                  err_ff   <= e_err;
                  total_ff <= entry_data[COUNT_BITS:0];
                  if (e_mode == MODE_NONE) begin
                     out_psnr_ff  <= '0;
                     out_ident_ff <= 1'b0;
                     out_valid_ff <= 1'b1;
                  end else if (e_err == '0) begin
                     out_psnr_ff  <= (e_mode == MODE_16BIT) ? CEIL_L16 : CEIL_L8;
                     out_ident_ff <= 1'b1;
                     out_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= B_WAIT;
                  end
               end
            end
            B_WAIT: begin
               signal_ff <= {32'd0, peak2} * {{(63-COUNT_BITS){1'b0}}, total_ff};
               state_ff  <= B_PROD;
            end
            B_PROD: state_ff <= B_LOGA;
            B_LOGA: begin
               if (log_done) begin
                  la_ff    <= log_res;
                  state_ff <= B_LOGB;
               end
            end
            B_LOGB: begin
               if (log_done) begin
                  neg_ff   <= dl[34];
                  mag_ff   <= dl[34] ? 34'(-dl) : dl[33:0];
                  state_ff <= B_SCALE;
               end
            end
            B_SCALE: begin
               prod_ff  <= mag_ff * KDB_Q16;
               state_ff <= B_ROUND;
            end
            B_ROUND: begin
               if (neg_ff) begin
                  out_psnr_ff <= (rnd > 17'd32768) ? 17'h10000 : 17'(-rnd);
               end else begin
                  out_psnr_ff <= rnd[16] ? 17'h0FFFF : rnd;
               end
               out_ident_ff <= 1'b0;
               out_valid_ff <= 1'b1;
               state_ff     <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_psnr      = out_psnr_ff;
   assign out_identical = out_ident_ff;

endmodule

// ----- src/psnr_checker.sv -----
module psnr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a pending result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // identical frames report one of the fixed ceilings
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd40481 || rsp_tdata == 24'd52820)
      else $error("identical flag without ceiling value");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind psnr_meter_unit psnr_checker u_psnr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
